// ----- rtl/asbf_pkg.sv -----
package asbf_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int VALUE_BITS_DEFAULT = 30;

   localparam int COUNT_BITS     = 11;
   localparam int INDEX_BITS     = 10;
   localparam int NEW_VALUE_BITS = 30;
   localparam int SUM_BITS       = 40;
   localparam int EPOCH_BITS     = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 11'd1024;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_FILL  = 1'b1;

   typedef struct packed {
      logic                      mode;
      logic [INDEX_BITS-1:0]     entry_index;
      logic [NEW_VALUE_BITS-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] total;
      logic                bad_index;
   } rsp_type;

   // epoch tracker status toward the datapath
   typedef struct packed {
      logic                  busy;
      logic                  wrap;
      logic [EPOCH_BITS-1:0] epoch;
   } epoch_stat_type;

endpackage

// ----- rtl/asbf_table.sv -----
module asbf_table
   import asbf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int WIDTH = VALUE_BITS_DEFAULT + EPOCH_BITS,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/asbf_epoch.sv -----
module asbf_epoch
   import asbf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fill,
   output epoch_stat_type       stat,
   output logic [ADDR_BITS-1:0] sweep_addr
);

   localparam logic [ADDR_BITS-1:0]  LAST_ADDR = ADDR_BITS'(DEPTH - 1);
   localparam logic [EPOCH_BITS-1:0] EPOCH_ONE = EPOCH_BITS'(1);

   logic                  busy_ff, busy_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic                  wrap;

   assign wrap = (epoch_ff == {EPOCH_BITS{1'b1}});

   always_comb begin
      busy_in  = busy_ff;
      addr_in  = addr_ff;
      epoch_in = epoch_ff;
      if (busy_ff) begin
         if (addr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
            addr_in = '0;
         end else begin
            addr_in = addr_ff + ADDR_BITS'(1);
         end
      end
      if (fill) begin
         if (wrap) begin
            // tags run out: restart at one and retag every entry stale
            epoch_in = EPOCH_ONE;
            busy_in  = 1'b1;
            addr_in  = '0;
         end else begin
            epoch_in = epoch_ff + EPOCH_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         addr_ff  <= '0;
         epoch_ff <= EPOCH_ONE;
      end else begin
         busy_ff  <= busy_in;
         addr_ff  <= addr_in;
         epoch_ff <= epoch_in;
      end
   end

   assign stat.busy  = busy_ff;
   assign stat.wrap  = wrap;
   assign stat.epoch = epoch_ff;
   assign sweep_addr = addr_ff;

endmodule

// ----- rtl/array_sum_with_bulk_fill.sv -----
// channel | ports                             | word
// req     | req_valid, req_ready, req_data    | req_type: mode, entry_index, new_value
// rsp     | rsp_valid, rsp_ready, rsp_data    | rsp_type: total, bad_index
// csr     | csr_valid, csr_ready, csr_data    | entry_count
//
// One word per cycle while rsp is not stalled and no retag is pending or running: table read on accept,
// update and write-back from the update stage register; the rsp word is registered behind that stage.
// After reset the table is retagged, entry by entry over all DEPTH entries, with req_ready low; the
// same pass follows every (2**EPOCH_BITS - 1)th fill.
// A stalled rsp holds the update stage and with it req_ready.
module array_sum_with_bulk_fill
   import asbf_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_BITS-1:0] csr_data
);

   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_BITS  = (ADDR_BITS + 1 > COUNT_BITS) ? ADDR_BITS + 1 : COUNT_BITS;
   localparam int WORD_BITS = EPOCH_BITS + VALUE_BITS;
   localparam int PROD_BITS = VALUE_BITS + CMP_BITS;
   localparam logic [CMP_BITS-1:0] DEPTH_CNT = CMP_BITS'(DEPTH);

   epoch_stat_type         stat;
   logic [ADDR_BITS-1:0]   sweep_addr;

   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [CMP_BITS-1:0]    eff_cnt, eff_ff;

   logic                   s1_valid_ff, s1_valid_in;
   req_type                s1_req_ff;
   logic                   s1_bad_ff, s1_bad_in;
   logic                   hit_ff, hit_in;
   logic [VALUE_BITS-1:0]  fwd_val_ff;

   logic [VALUE_BITS-1:0]  fill_ff, fill_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;

   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff;

   logic                   req_fire, s1_fire, s1_fill, s1_write_ok;
   logic [VALUE_BITS-1:0]  s1_val, rd_val, old_val;
   logic [EPOCH_BITS-1:0]  rd_tag;
   logic [WORD_BITS-1:0]   rd_word, wr_word;
   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [PROD_BITS-1:0]   prod;

   // configuration
   assign csr_ready = 1'b1;
   assign count_in  = (csr_valid && csr_ready) ? csr_data : count_ff;
   assign eff_cnt   = (CMP_BITS'(count_ff) > DEPTH_CNT) ? DEPTH_CNT : CMP_BITS'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         eff_ff   <= '0;
      end else begin
         count_ff <= count_in;
         eff_ff   <= eff_cnt;
      end
   end

   // handshakes
   assign s1_fill     = (s1_req_ff.mode == MODE_FILL);
   assign s1_write_ok = !s1_fill && !s1_bad_ff;
   assign s1_fire     = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !stat.busy && !(s1_valid_ff && s1_fill && stat.wrap)
                        && (!s1_valid_ff || s1_fire);
   assign req_fire    = req_valid && req_ready;

   // accept stage
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_fire);
   assign s1_bad_in   = (req_data.mode == MODE_WRITE)
                        && (CMP_BITS'(req_data.entry_index) >= eff_cnt);
   assign hit_in      = s1_fire && s1_write_ok
                        && (s1_req_ff.entry_index == req_data.entry_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff  <= req_data;
         s1_bad_ff  <= s1_bad_in;
         hit_ff     <= hit_in;
         fwd_val_ff <= s1_val;
      end
   end

   // table: {epoch tag, value}; tag unequal to the current epoch means stale
   asbf_table #(
      .DEPTH (DEPTH),
      .WIDTH (WORD_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (req_fire),
      .rd_addr (ADDR_BITS'(req_data.entry_index)),
      .rd_data (rd_word)
   );

   asbf_epoch #(
      .DEPTH (DEPTH)
   ) u_epoch (
      .clock      (clock),
      .reset      (reset),
      .fill       (s1_fire && s1_fill),
      .stat       (stat),
      .sweep_addr (sweep_addr)
   );

   // update stage
   assign s1_val  = VALUE_BITS'(s1_req_ff.new_value);
   assign rd_tag  = rd_word[WORD_BITS-1:VALUE_BITS];
   assign rd_val  = rd_word[VALUE_BITS-1:0];
   assign old_val = hit_ff ? fwd_val_ff : ((rd_tag != stat.epoch) ? fill_ff : rd_val);
   assign prod    = PROD_BITS'(s1_val) * PROD_BITS'(eff_ff);

   always_comb begin
      sum_in  = sum_ff;
      fill_in = fill_ff;
      if (s1_fire) begin
         if (s1_fill) begin
            fill_in = s1_val;
            sum_in  = SUM_BITS'(prod);
         end else if (!s1_bad_ff) begin
            sum_in = sum_ff + SUM_BITS'(s1_val) - SUM_BITS'(old_val);
         end
      end
   end

   assign wr_en   = stat.busy || (s1_fire && s1_write_ok);
   assign wr_addr = stat.busy ? sweep_addr : ADDR_BITS'(s1_req_ff.entry_index);
   assign wr_word = stat.busy ? '0 : {stat.epoch, s1_val};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         fill_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         fill_ff <= fill_in;
      end
   end

   // output register
   assign out_valid_in = s1_fire || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_ff.total     <= sum_in;
         out_ff.bad_index <= s1_bad_ff && !s1_fill;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // checks
   a_no_accept_in_sweep : assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !req_ready)
      else $error("word accepted during table retag");

   a_fill_moves_epoch : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_fill) |=> (stat.epoch != $past(stat.epoch)))
      else $error("fill did not advance epoch");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_req_ff)))
      else $error("update stage lost its word under stall");

   a_sum_only_on_fire : assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(sum_ff))
      else $error("sum changed without an update");

endmodule
